// ===== hw/rtl/asf_pkg.sv =====
// asf_pkg: beat types, character codes, filter modes and the
// controller/datapath command and status structs of the escape stripper.
// No dependencies.
`default_nettype none
package asf_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_chunk;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_beat_t;

	// filter modes
	localparam logic [1:0] MODE_RAW     = 2'd0;
	localparam logic [1:0] MODE_STRIP   = 2'd1;
	localparam logic [1:0] MODE_SGR     = 2'd2;
	localparam logic [1:0] MODE_RAW_ALT = 2'd3;

	// character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_BEL      = 8'h07;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_LBRK     = 8'h5B;
	localparam logic [7:0] CH_RBRK     = 8'h5D;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_SGR      = 8'h6D;
	localparam logic [7:0] CSI_FINAL_LO = 8'h40;
	localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

	typedef enum logic [1:0] {
		EMIT_ESC,
		EMIT_BRK,
		EMIT_PAR,
		EMIT_FIN
	} emit_sel_t;

	typedef struct packed {
		logic      take_in;
		logic      emit;
		emit_sel_t sel;
		logic      rd_issue;
	} asf_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic sgr_start;
		logic len_zero;
		logic idx_last;
	} asf_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ansi_escape_stripper_top.sv =====
// ansi_escape_stripper_top: top level of the terminal escape stripper.
// Depends on asf_pkg, asf_ctrl, asf_dp (and asf_ram through asf_dp).
//
// usage
// - src channel: one terminal byte per beat (data_byte, last_in_chunk),
//   taken when src_valid is high and src_stall is low
// - dst channel: filtered bytes, one per beat; last_of_run marks the final
//   byte caused by one input beat
// - cfg_we/cfg_data write filter_mode (raw, strip, strip but keep colour);
//   write it only while the block is idle
// - an ordinary byte is accepted and its result shows up in the output
//   register the next cycle; back-to-back bytes sustain one per cycle
//   while dst_stall is low, since the output register frees as it is taken
// - a kept colour sequence with n buffered parameter bytes replays as
//   n + 3 beats: each parameter is one registered read of the parameter
//   buffer plus one load of the output register; src_stall stays high
//   meanwhile
// - when dst_stall is high the output register holds its beat and src_stall
//   rises, so nothing is lost
// - reset clears the mode to raw and the parser to its normal state; the
//   parameter buffer needs no clearing since only written entries are read
`default_nettype none
module ansi_escape_stripper_top #(
	parameter int SGR_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input byte channel
	input  wire logic              src_valid,
	output logic                   src_stall,
	input  wire asf_pkg::in_beat_t src_beat,
	// filtered byte channel
	output logic                   dst_valid,
	input  wire logic              dst_stall,
	output asf_pkg::out_beat_t     dst_beat,
	// filter_mode register
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_data
);
	import asf_pkg::*;

	asf_cmd_t    cmd;
	asf_status_t status;

	// controller: handshake and colour sequence replay
	asf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath: parser state, parameter buffer, output register
	asf_dp #(
		.SGR_DEPTH(SGR_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.src_beat (src_beat),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_beat (dst_beat)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/asf_ram.sv =====
// asf_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module asf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/asf_ctrl.sv =====
// asf_ctrl: controller of the escape stripper; input handshake and the
// sequencer that replays a kept colour sequence. Depends on asf_pkg.
`default_nettype none
module asf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	output asf_pkg::asf_cmd_t        cmd,
	input  wire asf_pkg::asf_status_t status
);
	import asf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ESC,
		S_BRK,
		S_RD,
		S_PAR,
		S_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		src_stall    = 1'b1;
		cmd.take_in  = 1'b0;
		cmd.emit     = 1'b0;
		cmd.sel      = EMIT_ESC;
		cmd.rd_issue = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				src_stall   = !status.slot_free;
				cmd.take_in = src_valid && status.slot_free;
			end
			S_ESC: begin
				cmd.emit = status.slot_free;
				cmd.sel  = EMIT_ESC;
			end
			S_BRK: begin
				cmd.emit = status.slot_free;
				cmd.sel  = EMIT_BRK;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
			end
			S_PAR: begin
				cmd.emit = status.slot_free;
				cmd.sel  = EMIT_PAR;
			end
			S_FIN: begin
				cmd.emit = status.slot_free;
				cmd.sel  = EMIT_FIN;
			end
			default: begin
				src_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (src_valid && status.slot_free && status.sgr_start) begin
						state_q <= S_ESC;
					end
				end
				S_ESC: begin
					if (status.slot_free) begin
						state_q <= S_BRK;
					end
				end
				S_BRK: begin
					if (status.slot_free) begin
						state_q <= status.len_zero ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_PAR;
				end
				S_PAR: begin
					if (status.slot_free) begin
						state_q <= status.idx_last ? S_FIN : S_RD;
					end
				end
				S_FIN: begin
					if (status.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/asf_dp.sv =====
// asf_dp: datapath of the escape stripper; parser registers, parameter
// buffer, output register. Depends on asf_pkg and asf_ram.
`default_nettype none
module asf_dp #(
	parameter int SGR_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire asf_pkg::asf_cmd_t    cmd,
	output asf_pkg::asf_status_t      status,
	input  wire asf_pkg::in_beat_t    src_beat,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_data,
	output logic                      dst_valid,
	input  wire logic                 dst_stall,
	output asf_pkg::out_beat_t        dst_beat
);
	import asf_pkg::*;

	localparam int AW = $clog2(SGR_DEPTH);
	localparam int CW = $clog2(SGR_DEPTH + 1);

	typedef enum logic [1:0] {
		P_NORMAL,
		P_ESCAPE,
		P_CSI,
		P_OSC
	} parse_t;

	logic [1:0]    mode_q;
	parse_t        pstate_q, pstate_d;
	logic          prev_esc_q, prev_esc_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          ovf_q, ovf_d;
	logic [CW-1:0] len_q;
	logic [CW-1:0] idx_q;
	logic          pass;
	logic          sgr;
	logic          wr_en;
	logic          raw;
	logic [7:0]    c;
	logic [7:0]    rd_data;
	logic          out_valid_q;
	out_beat_t     out_beat_q;
	out_beat_t     emit_beat;
	logic          load;

	assign c   = src_beat.data_byte;
	assign raw = (mode_q == MODE_RAW) || (mode_q == MODE_RAW_ALT);

	// parser next state for the byte on the input
	always_comb begin
		pstate_d   = pstate_q;
		prev_esc_d = prev_esc_q;
		cnt_d      = cnt_q;
		ovf_d      = ovf_q;
		pass       = 1'b0;
		sgr        = 1'b0;
		wr_en      = 1'b0;
		if (raw) begin
			pass = 1'b1;
		end else begin
			unique case (pstate_q)
				P_NORMAL: begin
					if (c == CH_ESC) begin
						pstate_d = P_ESCAPE;
					end else if (c != CH_BEL && c != CH_BS) begin
						pass = 1'b1;
					end
				end
				P_ESCAPE: begin
					if (c == CH_LBRK) begin
						pstate_d = P_CSI;
						cnt_d    = '0;
						ovf_d    = 1'b0;
					end else if (c == CH_RBRK) begin
						pstate_d = P_OSC;
					end else begin
						pstate_d = P_NORMAL;
					end
				end
				P_CSI: begin
					if (c >= CSI_FINAL_LO && c <= CSI_FINAL_HI) begin
						sgr      = (mode_q == MODE_SGR) && (c == CH_SGR) && !ovf_q;
						pstate_d = P_NORMAL;
					end else if (cnt_q < CW'(SGR_DEPTH)) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end
				P_OSC: begin
					if (c == CH_BEL || (c == CH_BSLASH && prev_esc_q)) begin
						pstate_d = P_NORMAL;
					end
				end
				default: begin
					pstate_d = P_NORMAL;
				end
			endcase
			prev_esc_d = (c == CH_ESC);
		end
		// chunk end abandons any open sequence
		if (src_beat.last_in_chunk) begin
			pstate_d   = P_NORMAL;
			prev_esc_d = 1'b0;
			cnt_d      = '0;
			ovf_d      = 1'b0;
		end
	end

	asf_ram #(
		.WIDTH(8),
		.DEPTH(SGR_DEPTH)
	) u_param_ram (
		.clk    (clk),
		.wr_en  (cmd.take_in && wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(c),
		.rd_en  (cmd.rd_issue),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		emit_beat.last_of_run = 1'b0;
		case (cmd.sel)
			EMIT_ESC: emit_beat.out_byte = CH_ESC;
			EMIT_BRK: emit_beat.out_byte = CH_LBRK;
			EMIT_PAR: emit_beat.out_byte = rd_data;
			EMIT_FIN: begin
				emit_beat.out_byte    = CH_SGR;
				emit_beat.last_of_run = 1'b1;
			end
			default: emit_beat.out_byte = CH_ESC;
		endcase
	end

	assign load = (cmd.take_in && pass) || cmd.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RAW;
			pstate_q    <= P_NORMAL;
			prev_esc_q  <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.take_in) begin
				pstate_q   <= pstate_d;
				prev_esc_q <= prev_esc_d;
				cnt_q      <= cnt_d;
				ovf_q      <= ovf_d;
				len_q      <= cnt_q;
				idx_q      <= '0;
			end else if (cmd.emit && cmd.sel == EMIT_PAR) begin
				idx_q <= idx_q + CW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in && pass) begin
			out_beat_q.out_byte    <= c;
			out_beat_q.last_of_run <= 1'b1;
		end else if (cmd.emit) begin
			out_beat_q <= emit_beat;
		end
	end

	assign status.slot_free = !out_valid_q || !dst_stall;
	assign status.sgr_start = sgr;
	assign status.len_zero  = (len_q == '0);
	assign status.idx_last  = ((idx_q + CW'(1)) == len_q);

	assign dst_valid = out_valid_q;
	assign dst_beat  = out_beat_q;

endmodule
`default_nettype wire
